// ===== rtl/imufp_pkg.sv =====
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared types and constants for the IMU serial frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

  // Frame layout and byte codes.
  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] POS_HUNT  = 4'd0;
  localparam logic [PosW-1:0] POS_TYPE  = 4'd1;
  localparam logic [PosW-1:0] POS_PAY_LO = 4'd2;
  localparam logic [PosW-1:0] POS_PAY_HI = 4'd7;
  localparam logic [PosW-1:0] POS_SUM   = 4'd10;
  localparam logic [PosW-1:0] FRAME_LEN = 4'd11;

  localparam int unsigned PayBytes = 6;

  // Result kind codes.
  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;

  // Default depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One decoded frame.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } frame_rec_t;

  // Front-end request to the queue.
  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } push_t;

  // Queue status seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== rtl/imufp_front.sv =====
// ----------------------------------------------------------------------------
// imufp_front
// Accepts received bytes, tracks the frame position and checksum, and
// classifies each completed frame into a queue record.
// ----------------------------------------------------------------------------
module imufp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  imufp_pkg::q_status_t q_stat_i,
  output imufp_pkg::push_t    push_o
);
  import imufp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      type_q;
  logic [7:0]      pay_q [PayBytes];
  logic            accept;
  logic            hunting;
  logic            closing;
  logic            kind_ok;
  logic [1:0]      kind;
  logic [2:0]      pay_idx;

  // The checksum byte needs a free queue slot; every other byte is always taken.
  assign hunting    = (pos_q == POS_HUNT) || (pos_q >= FRAME_LEN);
  assign closing    = (pos_q == POS_SUM);
  assign in_ready_o = !(closing && q_stat_i.full);
  assign accept     = in_valid_i && in_ready_o;

  // Position and running checksum update.
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept) begin
      if (hunting) begin
        if (rx_byte_i == HDR_BYTE) begin
          pos_d = POS_TYPE;
          sum_d = HDR_BYTE;
        end else begin
          pos_d = POS_HUNT;
        end
      end else if (closing) begin
        pos_d = POS_HUNT;
      end else begin
        pos_d = pos_q + PosW'(1);
        sum_d = sum_q + rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HUNT;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Frame type and payload capture; these hold data only within a frame.
  assign pay_idx = 3'(pos_q - POS_PAY_LO);

  always_ff @(posedge clk_i) begin
    if (accept && !hunting) begin
      if (pos_q == POS_TYPE) begin
        type_q <= rx_byte_i;
      end else if (pos_q >= POS_PAY_LO && pos_q <= POS_PAY_HI) begin
        pay_q[pay_idx] <= rx_byte_i;
      end
    end
  end

  // Classify the frame type.
  always_comb begin
    kind_ok = 1'b1;
    kind    = KIND_ACCEL;
    case (type_q)
      TYPE_ACCEL: kind = KIND_ACCEL;
      TYPE_RATE:  kind = KIND_RATE;
      TYPE_ANGLE: kind = KIND_ANGLE;
      default:    kind_ok = 1'b0;
    endcase
  end

  // A good frame of a known type becomes one queue record.
  always_comb begin
    push_o.valid    = accept && closing && (sum_q == rx_byte_i) && kind_ok;
    push_o.rec.kind = kind;
    push_o.rec.x    = {pay_q[1], pay_q[0]};
    push_o.rec.y    = {pay_q[3], pay_q[2]};
    push_o.rec.z    = {pay_q[5], pay_q[4]};
  end

endmodule

// ===== rtl/imufp_fifo.sv =====
// ----------------------------------------------------------------------------
// imufp_fifo
// Short first-in first-out queue of decoded frames between front and back.
// ----------------------------------------------------------------------------
module imufp_fifo #(
  parameter int unsigned Depth = imufp_pkg::QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imufp_pkg::push_t      push_i,
  input  logic                  pop_i,
  output imufp_pkg::frame_rec_t head_o,
  output imufp_pkg::q_status_t  stat_o
);
  import imufp_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  frame_rec_t       mem [Depth];
  logic [AddrW-1:0] wr_q, wr_d;
  logic [AddrW-1:0] rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem[rd_q];

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= push_i.rec;
    end
  end

endmodule

// ===== rtl/imufp_back.sv =====
// ----------------------------------------------------------------------------
// imufp_back
// Output register stage: pulls records from the queue and holds each one on
// the result channel until it is taken.
// ----------------------------------------------------------------------------
module imufp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imufp_pkg::frame_rec_t head_i,
  input  imufp_pkg::q_status_t  q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output imufp_pkg::frame_rec_t rec_o
);
  import imufp_pkg::*;

  logic       vld_q, vld_d;
  frame_rec_t rec_q;

  // Load a new record whenever the register is empty or being emptied.
  assign pop_o = !q_stat_i.empty && (!vld_q || out_ready_i);

  always_comb begin
    vld_d = vld_q;
    if (pop_o) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= head_i;
    end
  end

  assign out_valid_o = vld_q;
  assign rec_o       = rec_q;

endmodule

// ===== rtl/imu_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// imu_frame_parser_core
// Parser for 11-byte sum-checked IMU frames arriving one byte per item.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_ready_o / rx_byte_i) takes one serial
// byte per item, one item per cycle. Bytes are dropped until a 0x55 header
// opens a frame; byte 10 of the frame is compared with the 8-bit sum of
// bytes 0 to 9. A good frame of type 0x51, 0x52 or 0x53 produces one item on
// the output channel (out_valid_o / out_ready_i) with its kind and three
// signed raw axis counts; other frames produce nothing.
// A result is written into the queue when its checksum byte is accepted,
// then moves from the queue into the output register, from which it is
// presented as valid on the output channel.
// Throughput: one byte per cycle. Only the checksum byte can be held off,
// when the frame queue is full; its depth is set by QueueDepth.
// When the receiver stalls, finished frames wait in the output register and
// the queue while the parser keeps taking bytes of the next frame.
// Reset returns the parser to hunting for a header and empties the queue.
// ----------------------------------------------------------------------------
module imu_frame_parser_core #(
  parameter int unsigned QueueDepth = imufp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         frame_kind_o,
  output logic signed [15:0] axis_x_o,
  output logic signed [15:0] axis_y_o,
  output logic signed [15:0] axis_z_o
);
  import imufp_pkg::*;

  push_t      push;
  q_status_t  q_stat;
  frame_rec_t head;
  frame_rec_t out_rec;
  logic       pop;

  // Front end: framing, checksum and classification.
  imufp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .q_stat_i   (q_stat),
    .push_o     (push)
  );

  // Queue of decoded frames.
  imufp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // Back end: output register.
  imufp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (out_rec)
  );

  assign frame_kind_o = out_rec.kind;
  assign axis_x_o     = out_rec.x;
  assign axis_y_o     = out_rec.y;
  assign axis_z_o     = out_rec.z;

`ifndef SYNTHESIS
  // The front end never offers a frame to a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_stat.full)
    else $error("frame pushed into full queue");

  // The queue is never both full and empty.
  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // A popped record is presented on the output in the next cycle.
  a_pop_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("popped record not presented");

  // Every presented result carries a defined kind.
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_kind_o == KIND_ACCEL || frame_kind_o == KIND_RATE ||
                     frame_kind_o == KIND_ANGLE))
    else $error("result with undefined kind");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the IMU frame parser. A byte-level model of the parser runs
// beside the block and queues the frame records it should emit; every record
// the block delivers is checked field by field against the oldest one queued.
// Directed frames cover the edge cases, then a long run of mostly well-formed
// frames with random content, corrupted sums and stray bytes follows. Both
// channels idle in short random bursts except during the final stretch.
// ----------------------------------------------------------------------------
module tb;
  import imufp_pkg::*;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte    = 8'h00;
  logic               out_valid;
  logic               out_ready  = 1'b0;
  logic [1:0]         frame_kind;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;

  // Parser model state.
  logic [PosW-1:0] parse_pos = POS_HUNT;
  logic [7:0]      parse_sum = 8'h00;
  logic [7:0]      parse_type = 8'h00;
  logic [7:0]      parse_pay [PayBytes];

  frame_rec_t frames_due [$];
  int         mismatch_cnt = 0;
  int         frame_bytes  = 0;
  bit         idle_on      = 1'b1;
  int         stall_left   = 0;

  imu_frame_parser_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .frame_kind_o(frame_kind),
    .axis_x_o    (axis_x),
    .axis_y_o    (axis_y),
    .axis_z_o    (axis_z)
  );

  always #2 clk = ~clk;

  // Advance the parser model by one accepted byte and queue any frame record.
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_rec_t rec;
    if (parse_pos == POS_HUNT || parse_pos >= FRAME_LEN) begin
      if (b == HDR_BYTE) begin
        parse_sum = HDR_BYTE;
        parse_pos = POS_TYPE;
      end else begin
        parse_pos = POS_HUNT;
      end
    end else if (parse_pos < POS_SUM) begin
      parse_sum = parse_sum + b;
      if (parse_pos == POS_TYPE) begin
        parse_type = b;
      end else if (parse_pos <= POS_PAY_HI) begin
        parse_pay[parse_pos - POS_PAY_LO] = b;
      end
      parse_pos = parse_pos + PosW'(1);
    end else begin
      // Checksum byte closes the frame either way.
      parse_pos = POS_HUNT;
      if (parse_sum == b) begin
        rec.kind = KIND_ACCEL;
        rec.x = {parse_pay[1], parse_pay[0]};
        rec.y = {parse_pay[3], parse_pay[2]};
        rec.z = {parse_pay[5], parse_pay[4]};
        case (parse_type)
          TYPE_ACCEL: begin
            rec.kind = KIND_ACCEL;
            frames_due.push_back(rec);
          end
          TYPE_RATE: begin
            rec.kind = KIND_RATE;
            frames_due.push_back(rec);
          end
          TYPE_ANGLE: begin
            rec.kind = KIND_ANGLE;
            frames_due.push_back(rec);
          end
          default: begin
          end
        endcase
      end
    end
  endtask

  // Offer one byte, optionally after a short idle burst, and wait for it to go.
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_rx_byte(b);
  endtask

  // Send header, type and eight data bytes, then the sum or a wrong one.
  // data[7:0] is frame byte 2, so the axis words sit little endian in data.
  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] data,
                            input bit corrupt);
    logic [7:0] sum;
    logic [7:0] fb;
    int i;
    sum = HDR_BYTE + ftype;
    send_byte(HDR_BYTE);
    send_byte(ftype);
    for (i = 0; i < 8; i++) begin
      fb  = data[8*i +: 8];
      sum = sum + fb;
      send_byte(fb);
    end
    if (corrupt) begin
      sum = sum + 8'($urandom_range(1, 255));
    end
    send_byte(sum);
  endtask

  task automatic check_field(input string fname, input logic [15:0] exp_v,
                             input logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname,
               $signed(exp_v), $signed(got_v));
      mismatch_cnt++;
    end
  endtask

  // Receiver: check each delivered item and pick the next ready value.
  always @(posedge clk) begin
    frame_rec_t exp_rec;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, got kind %0d x %0d y %0d z %0d",
                   $time, frame_kind, axis_x, axis_y, axis_z);
          mismatch_cnt++;
        end else begin
          exp_rec = frames_due.pop_front();
          check_field("frame_kind", {14'd0, exp_rec.kind}, {14'd0, frame_kind});
          check_field("axis_x", exp_rec.x, axis_x);
          check_field("axis_y", exp_rec.y, axis_y);
          check_field("axis_z", exp_rec.z, axis_z);
        end
      end
      if (idle_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Non-header bytes while hunting are dropped.
  task automatic test_hunt_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // Good acceleration frame with extreme axis values and 0x55 as plain data.
  task automatic test_accel_extremes();
    send_frame(TYPE_ACCEL, {8'h55, 8'h55, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b0);
  endtask

  // A bad sum discards the whole frame with no resync on an inner header,
  // and the next good frame parses normally.
  task automatic test_bad_sum_no_resync();
    send_frame(TYPE_RATE, {8'h55, 8'h51, 16'h5555, 16'h0155, 16'h5500}, 1'b1);
    send_frame(TYPE_ANGLE, {16'h0000, 16'h0000, 16'hFFFF, 16'h0001}, 1'b0);
  endtask

  // A good sum with an unknown type gives nothing; the type here is a header.
  task automatic test_unknown_type();
    send_frame(HDR_BYTE, {32'h1234_5678, 32'h9ABC_DEF0}, 1'b0);
    send_frame(TYPE_RATE, {16'hA5A5, 16'h0000, 16'h7FFF, 16'h8000}, 1'b0);
  endtask

  // Mostly well-formed frames with random content, plus stray bytes,
  // unknown types and corrupted sums. The last stretch runs without idling.
  task automatic test_random_stream();
    int         r;
    logic [7:0] ftype;
    while (frame_bytes < 1500) begin
      if (frame_bytes >= 1200) begin
        idle_on = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_byte(8'($urandom));
      end else begin
        if (r < 88) begin
          ftype = TYPE_ACCEL + 8'($urandom_range(0, 2));
        end else begin
          ftype = 8'($urandom);
        end
        send_frame(ftype, {$urandom, $urandom}, $urandom_range(0, 9) == 0);
        frame_bytes += 11;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hunt_noise();
    test_accel_extremes();
    test_bad_sum_no_resync();
    test_unknown_type();
    test_random_stream();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule
